// ===== sv/i2c_master_bit_sequencer_top_macros.svh =====
// ----------------------------------------------------------------------------
// I2C master bit sequencer assertion macros
// Shared assertion shorthands, clocked on clk with synchronous reset rst.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BIT_SEQUENCER_TOP_MACROS_SVH
`define I2C_MASTER_BIT_SEQUENCER_TOP_MACROS_SVH

// same-cycle implication
`define I2CMS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("i2cms assertion failed");

// next-cycle implication
`define I2CMS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("i2cms assertion failed");

`endif

// ===== sv/i2cms_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C master bit sequencer package
// Command codes, field widths and the per-beat result type.
// ----------------------------------------------------------------------------
package i2cms_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam int STEP_W        = 5;   // longest sequence is 20 phases
  localparam int HALF_W        = 8;
  localparam logic [HALF_W-1:0] HALF_RESET = 8'd5;

  localparam int S_DATA_W = 16;
  localparam int M_DATA_W = 16;
  localparam int FUNC_W   = 3;

  typedef enum logic [FUNC_W-1:0] {
    CMD_IDLE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4,
    CMD_ACKCK = 3'd5
  } cmd_t;

  typedef struct packed {
    logic [BITS_PER_BYTE-1:0] read_data;
    logic                     done;
    logic                     busy;
    logic                     sda;
    logic                     scl;
  } res_t;

endpackage

// ===== sv/i2c_master_bit_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// I2C master bit sequencer top level
// Tick-driven SCL/SDA sequencer with stream ports and a two-entry result queue.
// ----------------------------------------------------------------------------
// Each input beat is one timing tick and yields exactly one result beat holding
// the SCL/SDA drives, busy/done flags and the last read byte. The tick update is
// a single registered pass, so a beat is taken every clock cycle; results sit in
// a two-entry output queue, and the input stalls only when both entries are
// still waiting on the downstream side. The half-period register is written
// through cfg_we/cfg_wdata and should only change while the sequencer is idle.
module i2c_master_bit_sequencer_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [i2cms_pkg::HALF_W-1:0]       cfg_wdata,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [7:0] write_byte, [8] ack_after_read, [9] sda_in, [15:10] zero
  input  logic [i2cms_pkg::S_DATA_W-1:0]     s_axis_tdata,
  // [2:0] func
  input  logic [i2cms_pkg::FUNC_W-1:0]       s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [0] scl_out, [1] sda_out, [2] busy_res, [3] done_res, [11:4] read_data,
  // [15:12] zero
  output logic [i2cms_pkg::M_DATA_W-1:0]     m_axis_tdata
);

  logic            accept;
  logic            pop;
  i2cms_pkg::res_t res;
  i2cms_pkg::res_t queue [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;

  assign s_axis_tready = (count != 2'd2);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign pop           = m_axis_tvalid && m_axis_tready;

  i2cms_core u_core (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .accept         (accept),
    .func           (s_axis_tuser),
    .write_byte     (s_axis_tdata[7:0]),
    .ack_after_read (s_axis_tdata[8]),
    .sda_in         (s_axis_tdata[9]),
    .res            (res)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      queue[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (accept) wr_ptr <= !wr_ptr;
      if (pop)    rd_ptr <= !rd_ptr;
      count <= count + 2'(accept) - 2'(pop);
    end
  end

  assign m_axis_tvalid = (count != 2'd0);
  assign m_axis_tdata  = {4'd0, queue[rd_ptr].read_data, queue[rd_ptr].done,
                          queue[rd_ptr].busy, queue[rd_ptr].sda, queue[rd_ptr].scl};

endmodule

// ===== sv/i2cms_core.sv =====
// ----------------------------------------------------------------------------
// I2C master bit sequencer core
// Holds the sequence state and computes one tick per accepted beat.
// ----------------------------------------------------------------------------
module i2cms_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [i2cms_pkg::HALF_W-1:0]         cfg_wdata,
  input  logic                                 accept,
  input  logic [i2cms_pkg::FUNC_W-1:0]         func,
  input  logic [i2cms_pkg::BITS_PER_BYTE-1:0]  write_byte,
  input  logic                                 ack_after_read,
  input  logic                                 sda_in,
  output i2cms_pkg::res_t                      res
);

  localparam int BPB = i2cms_pkg::BITS_PER_BYTE;
  localparam int SW  = i2cms_pkg::STEP_W;
  localparam logic [SW-1:0] RD_BITS = SW'(2 * BPB);

  logic [i2cms_pkg::HALF_W-1:0] half_period_ticks;
  logic [i2cms_pkg::HALF_W-1:0] tick_count, tick_count_next;
  logic [SW-1:0]                step_index, step_index_next;
  logic [BPB-1:0]               shift_reg, shift_reg_next;
  logic [BPB-1:0]               last_read, last_read_next;
  i2cms_pkg::cmd_t              active_cmd, active_cmd_next;
  logic                         scl_level, scl_level_next;
  logic                         sda_level, sda_level_next;
  logic                         ack_choice, ack_choice_next;

  logic [i2cms_pkg::HALF_W-1:0] hp;
  logic [SW-1:0]                total;
  logic [SW-1:0]                step_inc;
  logic [1:0]                   pins;
  logic                         done;

  // pin drives on entry to phase k, returned as {scl, sda}
  function automatic logic [1:0] enter_phase(
    input i2cms_pkg::cmd_t cmd,
    input logic [SW-1:0]   k,
    input logic [BPB-1:0]  sh,
    input logic            ack,
    input logic            scl,
    input logic            sda
  );
    logic          c;
    logic          d;
    logic [SW-1:0] j;
    c = scl;
    d = sda;
    j = k - RD_BITS;
    case (cmd)
      i2cms_pkg::CMD_START: begin
        c = (k == '0);
        d = (k == '0);
      end
      i2cms_pkg::CMD_STOP: begin
        c = 1'b1;
        d = 1'b0;
      end
      i2cms_pkg::CMD_WRITE: begin
        if (!k[0]) begin
          if (k != '0) c = 1'b0;
          d = sh[3'(3'(BPB - 1) - k[3:1])];
        end else begin
          c = 1'b1;
        end
      end
      i2cms_pkg::CMD_READ: begin
        if (k < RD_BITS) begin
          if (!k[0]) begin
            if (k == '0) d = 1'b1;
            c = 1'b1;
          end else begin
            c = 1'b0;
          end
        end else begin
          case (j[1:0])
            2'd0:    d = !ack;
            2'd1:    c = 1'b1;
            2'd2:    c = 1'b0;
            default: d = 1'b1;
          endcase
        end
      end
      i2cms_pkg::CMD_ACKCK: c = (k == '0);
      default: ;
    endcase
    return {c, d};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period_ticks <= i2cms_pkg::HALF_RESET;
    end else if (cfg_we) begin
      half_period_ticks <= cfg_wdata;
    end
  end

  assign hp = (half_period_ticks == '0) ? 8'd1 : half_period_ticks;

  always_comb begin
    active_cmd_next = active_cmd;
    ack_choice_next = ack_choice;
    shift_reg_next  = shift_reg;
    step_index_next = step_index;
    tick_count_next = tick_count;
    scl_level_next  = scl_level;
    sda_level_next  = sda_level;
    last_read_next  = last_read;
    done            = 1'b0;
    total           = '0;
    step_inc        = '0;
    pins            = '0;

    if (active_cmd == i2cms_pkg::CMD_IDLE && func >= 3'(i2cms_pkg::CMD_START)
        && func <= 3'(i2cms_pkg::CMD_ACKCK)) begin
      active_cmd_next = i2cms_pkg::cmd_t'(func);
      ack_choice_next = ack_after_read;
      shift_reg_next  = (active_cmd_next == i2cms_pkg::CMD_WRITE) ? write_byte : '0;
      step_index_next = '0;
      tick_count_next = '0;
      pins = enter_phase(active_cmd_next, '0, shift_reg_next, ack_choice_next,
                         scl_level, sda_level);
      scl_level_next = pins[1];
      sda_level_next = pins[0];
    end

    if (active_cmd_next != i2cms_pkg::CMD_IDLE) begin
      tick_count_next = tick_count_next + 8'd1;
      if (tick_count_next >= hp) begin
        // read samples SDA at the end of each SCL-high phase
        if (active_cmd_next == i2cms_pkg::CMD_READ && step_index_next < RD_BITS &&
            !step_index_next[0]) begin
          shift_reg_next = {shift_reg_next[BPB-2:0], sda_in};
        end
        case (active_cmd_next)
          i2cms_pkg::CMD_START: total = SW'(2);
          i2cms_pkg::CMD_STOP:  total = SW'(1);
          i2cms_pkg::CMD_WRITE: total = RD_BITS;
          i2cms_pkg::CMD_READ:  total = ack_choice_next ? RD_BITS + SW'(4)
                                                        : RD_BITS + SW'(3);
          i2cms_pkg::CMD_ACKCK: total = SW'(2);
          default:              total = '0;
        endcase
        tick_count_next = '0;
        step_inc = step_index_next + SW'(1);
        if (step_inc >= total) begin
          if (active_cmd_next == i2cms_pkg::CMD_STOP)  sda_level_next = 1'b1;
          if (active_cmd_next == i2cms_pkg::CMD_WRITE) scl_level_next = 1'b0;
          if (active_cmd_next == i2cms_pkg::CMD_READ)  last_read_next = shift_reg_next;
          active_cmd_next = i2cms_pkg::CMD_IDLE;
          step_index_next = '0;
          done            = 1'b1;
        end else begin
          step_index_next = step_inc;
          pins = enter_phase(active_cmd_next, step_inc, shift_reg_next,
                             ack_choice_next, scl_level_next, sda_level_next);
          scl_level_next = pins[1];
          sda_level_next = pins[0];
        end
      end
    end
  end

  always_comb begin
    res.scl       = scl_level_next;
    res.sda       = sda_level_next;
    res.busy      = (active_cmd_next != i2cms_pkg::CMD_IDLE);
    res.done      = done;
    res.read_data = last_read_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_cmd <= i2cms_pkg::CMD_IDLE;
      tick_count <= '0;
      step_index <= '0;
      shift_reg  <= '0;
      scl_level  <= 1'b1;
      sda_level  <= 1'b1;
      ack_choice <= 1'b0;
      last_read  <= '0;
    end else if (accept) begin
      active_cmd <= active_cmd_next;
      tick_count <= tick_count_next;
      step_index <= step_index_next;
      shift_reg  <= shift_reg_next;
      scl_level  <= scl_level_next;
      sda_level  <= sda_level_next;
      ack_choice <= ack_choice_next;
      last_read  <= last_read_next;
    end
  end

`include "i2c_master_bit_sequencer_top_macros.svh"

  `I2CMS_ASSERT_NOW(a_done_not_busy, accept && res.done, !res.busy)
  `I2CMS_ASSERT_NOW(a_idle_clean, active_cmd == i2cms_pkg::CMD_IDLE, step_index == '0)
  `I2CMS_ASSERT_NOW(a_step_range, 1'b1, step_index < RD_BITS + SW'(4))
  `I2CMS_ASSERT_NEXT(a_hold_state, !accept, $stable(active_cmd) && $stable(last_read))

endmodule
